FILE: design/wspt_pkg.sv
// Package for the wheel speed PID throttle block: field widths, register
// indexes, state and control types, reset values and the rounding function.
// It depends on nothing else; every other file of the block imports it.
`default_nettype none

package wspt_pkg;

   localparam int PULSE_W    = 11;
   localparam int SPEED_W    = 26;
   localparam int ERR_W      = 27;
   localparam int DIFF_W     = 28;
   localparam int DERIV_W    = 29;
   localparam int SUM_W      = 48;
   localparam int ACC_W      = 64;
   localparam int MOP_W      = 33;
   localparam int PROD_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int THR_W      = 7;
   localparam int THR_INT_W  = 8;
   localparam int PW_W       = 12;
   localparam int HI_W       = 38;
   localparam int IPOS_W     = 63;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [IPOS_W-1:0]  ITERM_CAP = {1'b1, {(IPOS_W-1){1'b0}}};
   localparam logic [PW_W-1:0]    PW_LOW    = 12'd900;
   localparam logic [PW_W-1:0]    PW_MIN    = 12'd1500;
   localparam logic [PW_W-1:0]    PW_MAX    = 12'd2100;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SET_SPEED,
      REG_SPEED_PER_PULSE,
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_STEP_MS,
      REG_DERIV_SCALE
   } reg_index_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2
   } clamp_type;

   typedef struct packed {
      logic signed [23:0] set_speed;
      logic [15:0]        speed_per_pulse;
      logic [23:0]        gain_p;
      logic [23:0]        gain_i;
      logic [23:0]        gain_d;
      logic [9:0]         step_ms;
      logic [31:0]        deriv_scale;
   } cfg_type;

   localparam logic [23:0] RST_SET_SPEED       = 24'd0;
   localparam logic [15:0] RST_SPEED_PER_PULSE = 16'd4806;
   localparam logic [23:0] RST_GAIN_P          = 24'd327680;
   localparam logic [23:0] RST_GAIN_I          = 24'd655;
   localparam logic [23:0] RST_GAIN_D          = 24'd6554;
   localparam logic [9:0]  RST_STEP_MS         = 10'd100;
   localparam logic [31:0] RST_DERIV_SCALE     = 32'd42950;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MSPD,
      ST_ERR,
      ST_MINT,
      ST_MDIF,
      ST_MP,
      ST_MIH,
      ST_MIL,
      ST_MD,
      ST_ACCI,
      ST_ACCD,
      ST_RND,
      ST_CLMP,
      ST_MPW,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MS_SPEED,
      MS_INT,
      MS_DIFF,
      MS_GP,
      MS_IHI,
      MS_ILO,
      MS_GD,
      MS_PW
   } mul_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        ld_err;
      logic        ld_diff;
      logic        ld_esum;
      logic        ld_deriv;
      logic        ld_accp;
      logic        ld_hi;
      logic        ld_ipos;
      logic        add_i;
      logic        add_d;
      logic        ld_rnd;
      logic        ld_thr;
      logic        ld_out;
   } ctrl_type;

   // Divides by 2^32 with rounding half away from zero.
   function automatic logic signed [31:0] round32(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-1:0] bias;
      logic [ACC_W-1:0] s;
      bias = x[ACC_W-1] ? 64'h0000_0000_7FFF_FFFF : 64'h0000_0000_8000_0000;
      s = x + bias;
      return s[63:32];
   endfunction

endpackage

`default_nettype wire

FILE: design/wspt_req_if.sv
// Input channel interface carrying one pulse count per transaction.
// Depends on wspt_pkg for the field width.
`default_nettype none

interface wspt_req_if import wspt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PULSE_W-1:0] pulse_count;

   modport source (output valid, output pulse_count, input ready);
   modport sink (input valid, input pulse_count, output ready);
endinterface

`default_nettype wire

FILE: design/wspt_rsp_if.sv
// Result channel interface carrying throttle, pulse width, speed and clamp state.
// Depends on wspt_pkg for the field widths.
`default_nettype none

interface wspt_rsp_if import wspt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [THR_W-1:0]          throttle;
   logic [PW_W-1:0]           pulse_width_us;
   logic signed [SPEED_W-1:0] speed;
   logic [1:0]                clamp_state;

   modport source (output valid, output throttle, output pulse_width_us, output speed,
                   output clamp_state, input ready);
   modport sink (input valid, input throttle, input pulse_width_us, input speed,
                 input clamp_state, output ready);
endinterface

`default_nettype wire

FILE: design/wspt_csr_if.sv
// Configuration write interface: register index and write data per transaction.
// Depends on wspt_pkg for the field widths.
`default_nettype none

interface wspt_csr_if import wspt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/wspt_csr.sv
// Configuration register file of the wheel speed PID throttle block.
// Depends on wspt_pkg and wspt_csr_if.
`default_nettype none

module wspt_csr import wspt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wspt_csr_if.sink   csr_ch,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = !reset;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (reg_index_type'(csr_ch.index))
            REG_SET_SPEED:       cfg_in.set_speed       = csr_ch.data[23:0];
            REG_SPEED_PER_PULSE: cfg_in.speed_per_pulse = csr_ch.data[15:0];
            REG_GAIN_P:          cfg_in.gain_p          = csr_ch.data[23:0];
            REG_GAIN_I:          cfg_in.gain_i          = csr_ch.data[23:0];
            REG_GAIN_D:          cfg_in.gain_d          = csr_ch.data[23:0];
            REG_STEP_MS:         cfg_in.step_ms         = csr_ch.data[9:0];
            REG_DERIV_SCALE:     cfg_in.deriv_scale     = csr_ch.data[31:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_speed       <= RST_SET_SPEED;
         cfg_ff.speed_per_pulse <= RST_SPEED_PER_PULSE;
         cfg_ff.gain_p          <= RST_GAIN_P;
         cfg_ff.gain_i          <= RST_GAIN_I;
         cfg_ff.gain_d          <= RST_GAIN_D;
         cfg_ff.step_ms         <= RST_STEP_MS;
         cfg_ff.deriv_scale     <= RST_DERIV_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/wspt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on wspt_pkg for the operand and product widths.
`default_nettype none

module wspt_mul import wspt_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [MOP_W-1:0]  op_a,
   input  logic signed [MOP_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [2*MOP_W-1:0] full;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;

   assign full    = op_a * op_b;
   assign prod_in = en ? full[PROD_W-1:0] : prod_ff;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

FILE: design/wspt_fsm.sv
// Sequencer of the wheel speed PID throttle block: steps one item through the
// shared multiplier and the accumulator. Depends on wspt_pkg.
`default_nettype none

module wspt_fsm import wspt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_fire,
   input  logic      out_free,
   output state_type state,
   output ctrl_type  ctrl
);

   state_type state_ff;
   state_type state_in;

   assign state = state_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_MSPD;
         ST_MSPD: state_in = ST_ERR;
         ST_ERR:  state_in = ST_MINT;
         ST_MINT: state_in = ST_MDIF;
         ST_MDIF: state_in = ST_MP;
         ST_MP:   state_in = ST_MIH;
         ST_MIH:  state_in = ST_MIL;
         ST_MIL:  state_in = ST_MD;
         ST_MD:   state_in = ST_ACCI;
         ST_ACCI: state_in = ST_ACCD;
         ST_ACCD: state_in = ST_RND;
         ST_RND:  state_in = ST_CLMP;
         ST_CLMP: state_in = ST_MPW;
         ST_MPW:  state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = MS_SPEED;
      case (state_ff)
         ST_IDLE: ctrl.req_ready = 1'b1;
         ST_MSPD: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_SPEED;
         end
         ST_ERR:  ctrl.ld_err = 1'b1;
         ST_MINT: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_INT;
            ctrl.ld_diff = 1'b1;
         end
         ST_MDIF: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_DIFF;
            ctrl.ld_esum = 1'b1;
         end
         ST_MP: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = MS_GP;
            ctrl.ld_deriv = 1'b1;
         end
         ST_MIH: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_IHI;
            ctrl.ld_accp = 1'b1;
         end
         ST_MIL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_ILO;
            ctrl.ld_hi   = 1'b1;
         end
         ST_MD: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_GD;
            ctrl.ld_ipos = 1'b1;
         end
         ST_ACCI: ctrl.add_i  = 1'b1;
         ST_ACCD: ctrl.add_d  = 1'b1;
         ST_RND:  ctrl.ld_rnd = 1'b1;
         ST_CLMP: ctrl.ld_thr = 1'b1;
         ST_MPW: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_PW;
         end
         ST_OUT:  ctrl.ld_out = out_free;
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/wheel_speed_pid_throttle.sv
// Wheel speed PID throttle controller: top level with the datapath registers.
// Depends on wspt_pkg, the three channel interfaces, wspt_csr, wspt_mul and wspt_fsm.
//
// Each transaction on req_ch brings the signed pulse count of one sample period.
// The block turns it into a wheel speed, runs one PID update against the set
// speed and returns one transaction on rsp_ch with the clamped throttle, the ESC
// pulse width, the measured speed and the clamp state.
// The csr_ch channel writes the configuration registers; it is ready whenever
// reset is low and must be used only while the block is idle.
// All eight multiplications of one item pass one after another through a single
// 33 by 33 bit multiplier, and the sequencer runs one step per cycle except that it
// waits in its output state until the output register is free. A new item is
// accepted at the earliest in the cycle after the previous result is loaded: the
// block does not take a new item before it is through with the last one.
// The result sits in an output register: the block takes the next item while it
// waits, and if the receiver stalls it holds the following result until the
// register is free.
// Reset restores the register defaults and clears the error integral and the
// previous error.
`default_nettype none

module wheel_speed_pid_throttle import wspt_pkg::*; #(
   parameter int MAX_THROTTLE = 100
) (
   input  logic        clock,
   input  logic        reset,
   wspt_req_if.sink    req_ch,
   wspt_rsp_if.source  rsp_ch,
   wspt_csr_if.sink    csr_ch
);

   localparam logic [63:0] PW_DIV   = 64'(2 * MAX_THROTTLE);
   localparam int          PW_SHIFT = 20 + $clog2(2 * MAX_THROTTLE);
   localparam logic [63:0] PW_RECIP = ((64'd1 << PW_SHIFT) + PW_DIV - 64'd1) / PW_DIV;
   localparam logic [63:0] PW_MULT  = PW_RECIP * 64'd1200;
   localparam logic [THR_INT_W-1:0] MAX_THR = THR_INT_W'(MAX_THROTTLE);

   cfg_type   cfg;
   state_type state;
   ctrl_type  ctrl;
   logic      req_fire;
   logic      out_free;

   logic signed [MOP_W-1:0]  op_a;
   logic signed [MOP_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [PULSE_W-1:0] pulse_ff, pulse_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   last_ff, last_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [SUM_W-1:0]   esum_ff, esum_in;
   logic [SUM_W-1:0]          emag_ff, emag_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      hicap_ff, hicap_in;
   logic [HI_W-1:0]           hi_ff, hi_in;
   logic [IPOS_W-1:0]         ipos_ff, ipos_in;
   logic signed [31:0]        rnd_ff, rnd_in;
   logic [THR_INT_W-1:0]      thr_ff, thr_in;
   clamp_type                 clamp_ff, clamp_in;
   logic [THR_INT_W-1:0]      out_thr_ff, out_thr_in;
   logic [PW_W-1:0]           out_pw_ff, out_pw_in;
   logic signed [SPEED_W-1:0] out_speed_ff, out_speed_in;
   clamp_type                 out_clamp_ff, out_clamp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [26:0]           prod27;
   logic [SPEED_W-1:0]    spd_sat;
   logic [SUM_W:0]        esum_sum;
   logic [IPOS_W-1:0]     ipos_sum;
   logic signed [31:0]    deriv_rnd;
   logic signed [31:0]    acc_rnd;
   logic [THR_INT_W:0]    thr_off;
   logic [10:0]           pw_q;

   assign req_ch.ready = ctrl.req_ready && !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   wspt_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   wspt_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .state    (state),
      .ctrl     (ctrl)
   );

   wspt_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign thr_off = {1'b0, thr_ff} + (THR_INT_W + 1)'(MAX_THROTTLE);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctrl.mul_sel)
         MS_SPEED: begin
            op_a = {{(MOP_W-PULSE_W){pulse_ff[PULSE_W-1]}}, pulse_ff};
            op_b = {17'd0, cfg.speed_per_pulse};
         end
         MS_INT: begin
            op_a = {{(MOP_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            op_b = {23'd0, cfg.step_ms};
         end
         MS_DIFF: begin
            op_a = {{(MOP_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
            op_b = {1'b0, cfg.deriv_scale};
         end
         MS_GP: begin
            op_a = {{(MOP_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            op_b = {9'd0, cfg.gain_p};
         end
         MS_IHI: begin
            op_a = {9'd0, emag_ff[47:24]};
            op_b = {9'd0, cfg.gain_i};
         end
         MS_ILO: begin
            op_a = {9'd0, emag_ff[23:0]};
            op_b = {9'd0, cfg.gain_i};
         end
         MS_GD: begin
            op_a = {{(MOP_W-DERIV_W){deriv_ff[DERIV_W-1]}}, deriv_ff};
            op_b = {9'd0, cfg.gain_d};
         end
         MS_PW: begin
            op_a = {{(MOP_W-THR_INT_W-1){1'b0}}, thr_off};
            op_b = PW_MULT[MOP_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod27   = prod[26:0];
   assign spd_sat  = (prod27[26] != prod27[25]) ? (prod27[26] ? SPEED_MIN : SPEED_MAX)
                                                : prod27[25:0];
   assign esum_sum = {esum_ff[SUM_W-1], esum_ff} + prod[SUM_W:0];
   assign ipos_sum = {1'b0, hi_ff, 24'd0} + {15'd0, prod[47:0]};
   assign deriv_rnd = round32(prod);
   assign acc_rnd   = round32(acc_ff);
   assign pw_q      = prod[PW_SHIFT +: 11];

   always_comb begin
      pulse_in     = req_fire ? req_ch.pulse_count : pulse_ff;
      speed_in     = speed_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      esum_in      = esum_ff;
      emag_in      = emag_ff;
      deriv_in     = deriv_ff;
      acc_in       = acc_ff;
      hicap_in     = hicap_ff;
      hi_in        = hi_ff;
      ipos_in      = ipos_ff;
      rnd_in       = rnd_ff;
      thr_in       = thr_ff;
      clamp_in     = clamp_ff;
      out_thr_in   = out_thr_ff;
      out_pw_in    = out_pw_ff;
      out_speed_in = out_speed_ff;
      out_clamp_in = out_clamp_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;

      if (ctrl.ld_err) begin
         speed_in = spd_sat;
         err_in   = {{3{cfg.set_speed[23]}}, cfg.set_speed} - {spd_sat[SPEED_W-1], spd_sat};
      end
      if (ctrl.ld_diff) begin
         diff_in = {err_ff[ERR_W-1], err_ff} - {last_ff[ERR_W-1], last_ff};
         last_in = err_ff;
      end
      if (ctrl.ld_esum) begin
         if (esum_sum[SUM_W] != esum_sum[SUM_W-1]) begin
            esum_in = esum_sum[SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            esum_in = esum_sum[SUM_W-1:0];
         end
      end
      if (ctrl.ld_deriv) begin
         deriv_in = deriv_rnd[DERIV_W-1:0];
         emag_in  = esum_ff[SUM_W-1] ? (SUM_W'(0) - esum_ff) : esum_ff;
      end
      if (ctrl.ld_accp) begin
         acc_in = prod;
      end
      if (ctrl.ld_hi) begin
         hicap_in = (prod[47:HI_W] != '0);
         hi_in    = prod[HI_W-1:0];
      end
      if (ctrl.ld_ipos) begin
         ipos_in = (hicap_ff || ipos_sum > ITERM_CAP) ? ITERM_CAP : ipos_sum;
      end
      if (ctrl.add_i) begin
         acc_in = esum_ff[SUM_W-1] ? (acc_ff - {1'b0, ipos_ff}) : (acc_ff + {1'b0, ipos_ff});
      end
      if (ctrl.add_d) begin
         acc_in = acc_ff + prod;
      end
      if (ctrl.ld_rnd) begin
         rnd_in = acc_rnd;
      end
      if (ctrl.ld_thr) begin
         if (rnd_ff > $signed({24'd0, MAX_THR})) begin
            thr_in   = MAX_THR;
            clamp_in = CLAMP_HIGH;
         end else if (rnd_ff[31]) begin
            thr_in   = '0;
            clamp_in = CLAMP_LOW;
         end else begin
            thr_in   = rnd_ff[THR_INT_W-1:0];
            clamp_in = CLAMP_NONE;
         end
      end
      if (ctrl.ld_out) begin
         out_thr_in   = thr_ff;
         out_pw_in    = {1'b0, pw_q} + PW_LOW;
         out_speed_in = speed_ff;
         out_clamp_in = clamp_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         esum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         esum_ff      <= esum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pulse_ff     <= pulse_in;
      speed_ff     <= speed_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      emag_ff      <= emag_in;
      deriv_ff     <= deriv_in;
      acc_ff       <= acc_in;
      hicap_ff     <= hicap_in;
      hi_ff        <= hi_in;
      ipos_ff      <= ipos_in;
      rnd_ff       <= rnd_in;
      thr_ff       <= thr_in;
      clamp_ff     <= clamp_in;
      out_thr_ff   <= out_thr_in;
      out_pw_ff    <= out_pw_in;
      out_speed_ff <= out_speed_in;
      out_clamp_ff <= out_clamp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.throttle       = out_thr_ff[THR_W-1:0];
   assign rsp_ch.pulse_width_us = out_pw_ff;
   assign rsp_ch.speed          = out_speed_ff;
   assign rsp_ch.clamp_state    = out_clamp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state == ST_MSPD) && !req_ch.ready)
      else $error("sequencer did not start after an accepted transaction");

   a_clamp_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_clamp_ff == CLAMP_HIGH) |-> out_thr_ff == MAX_THR)
      else $error("high clamp without full throttle");

   a_clamp_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_clamp_ff == CLAMP_LOW) |-> out_thr_ff == '0)
      else $error("low clamp without zero throttle");

   a_pw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_pw_ff >= PW_MIN && out_pw_ff <= PW_MAX
                        && out_thr_ff <= MAX_THR))
      else $error("pulse width or throttle out of range");

endmodule

`default_nettype wire

FILE: bench/wheel_speed_pid_throttle_check.sv
// Checker for the wheel speed PID throttle block: it watches the three channels,
// predicts each result from its own copy of the registers and PID state, and compares.
// Depends on wspt_pkg for field widths, register indexes, clamp codes and reset values.

module wheel_speed_pid_throttle_check import wspt_pkg::*; #(
   parameter int MAX_THROTTLE = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [PULSE_W-1:0] req_pulse_count,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [THR_W-1:0]          rsp_throttle,
   input  logic [PW_W-1:0]           rsp_pulse_width_us,
   input  logic signed [SPEED_W-1:0] rsp_speed,
   input  logic [1:0]                rsp_clamp_state,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output int                        outstanding,
   output int                        failures
);

   localparam longint SPEED_TOP    = 64'sd33554431;
   localparam longint SPEED_BOTTOM = -64'sd33554432;
   localparam longint INTEG_TOP    = 64'sd140737488355327;
   localparam longint INTEG_BOTTOM = -64'sd140737488355328;
   localparam longint unsigned ITERM_LIMIT = 64'h4000_0000_0000_0000;
   localparam longint unsigned HI_LIMIT    = 64'h0000_0040_0000_0000;
   localparam longint unsigned HALF_LSB    = 64'h0000_0000_8000_0000;
   localparam longint PW_BASE = 900;
   localparam longint PW_SPAN = 1200;

   typedef struct {
      logic [THR_W-1:0]          throttle;
      logic [PW_W-1:0]           pulse_width_us;
      logic signed [SPEED_W-1:0] speed;
      clamp_type                 clamp_state;
   } throttle_result_type;

   cfg_type             regs;
   longint              error_integral;
   longint              previous_error;
   throttle_result_type pending_results[$];
   int                  fail_count;

   function automatic longint unsigned magnitude(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic longint saturate(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic longint round_half_away(input longint x);
      longint r;
      r = longint'((magnitude(x) + HALF_LSB) >> 32);
      return (x < 0) ? -r : r;
   endfunction

   function automatic throttle_result_type predict_throttle(
      input logic signed [PULSE_W-1:0] pulses);
      longint              speed_l;
      longint              err;
      longint              diff;
      longint              deriv;
      longint              iterm;
      longint              total;
      longint              thr;
      longint              pulse_us;
      longint unsigned     dprod;
      longint unsigned     imag;
      longint unsigned     ihigh;
      longint unsigned     iprod;
      clamp_type           clamp;
      throttle_result_type res;
      speed_l = saturate(longint'(pulses) * longint'(regs.speed_per_pulse),
                         SPEED_BOTTOM, SPEED_TOP);
      err = longint'($signed(regs.set_speed)) - speed_l;
      error_integral = saturate(error_integral + err * longint'(regs.step_ms),
                                INTEG_BOTTOM, INTEG_TOP);
      diff = err - previous_error;
      dprod = magnitude(diff) * regs.deriv_scale;
      deriv = round_half_away((diff < 0) ? -longint'(dprod) : longint'(dprod));
      previous_error = err;

      imag = magnitude(error_integral);
      ihigh = (imag >> 24) * regs.gain_i;
      if (ihigh >= HI_LIMIT) begin
         iprod = ITERM_LIMIT;
      end else begin
         iprod = (ihigh << 24) + (imag & 64'hFF_FFFF) * regs.gain_i;
         if (iprod > ITERM_LIMIT) begin
            iprod = ITERM_LIMIT;
         end
      end
      iterm = (error_integral < 0) ? -longint'(iprod) : longint'(iprod);

      total = err * longint'(regs.gain_p) + iterm + deriv * longint'(regs.gain_d);
      thr = round_half_away(total);
      clamp = CLAMP_NONE;
      if (thr > MAX_THROTTLE) begin
         thr = MAX_THROTTLE;
         clamp = CLAMP_HIGH;
      end else if (thr < 0) begin
         thr = 0;
         clamp = CLAMP_LOW;
      end
      pulse_us = (thr + MAX_THROTTLE) * PW_SPAN / (2 * MAX_THROTTLE) + PW_BASE;

      res.throttle = THR_W'(thr);
      res.pulse_width_us = PW_W'(pulse_us);
      res.speed = SPEED_W'(speed_l);
      res.clamp_state = clamp;
      return res;
   endfunction

   always @(posedge clock) begin
      throttle_result_type want;
      if (reset) begin
         regs.set_speed = RST_SET_SPEED;
         regs.speed_per_pulse = RST_SPEED_PER_PULSE;
         regs.gain_p = RST_GAIN_P;
         regs.gain_i = RST_GAIN_I;
         regs.gain_d = RST_GAIN_D;
         regs.step_ms = RST_STEP_MS;
         regs.deriv_scale = RST_DERIV_SCALE;
         error_integral = 0;
         previous_error = 0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SET_SPEED:       regs.set_speed = csr_data[23:0];
               REG_SPEED_PER_PULSE: regs.speed_per_pulse = csr_data[15:0];
               REG_GAIN_P:          regs.gain_p = csr_data[23:0];
               REG_GAIN_I:          regs.gain_i = csr_data[23:0];
               REG_GAIN_D:          regs.gain_d = csr_data[23:0];
               REG_STEP_MS:         regs.step_ms = csr_data[9:0];
               REG_DERIV_SCALE:     regs.deriv_scale = csr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with no expectation: throttle %0d speed %0d",
                      rsp_throttle, rsp_speed);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_throttle !== want.throttle) begin
                  $error("throttle: expected %0d, got %0d", want.throttle, rsp_throttle);
                  fail_count++;
               end
               if (rsp_pulse_width_us !== want.pulse_width_us) begin
                  $error("pulse_width_us: expected %0d, got %0d",
                         want.pulse_width_us, rsp_pulse_width_us);
                  fail_count++;
               end
               if (rsp_speed !== want.speed) begin
                  $error("speed: expected %0d, got %0d", want.speed, rsp_speed);
                  fail_count++;
               end
               if (rsp_clamp_state !== want.clamp_state) begin
                  $error("clamp_state: expected %0d, got %0d",
                         want.clamp_state, rsp_clamp_state);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(predict_throttle(req_pulse_count));
         end
      end
      outstanding <= pending_results.size();
      failures <= fail_count;
   end

endmodule

FILE: bench/wheel_speed_pid_throttle_tb.sv
// Top of the wheel speed PID throttle regression: clock, reset, register set-up,
// directed and random pulse counts, receiver stalls and the final verdict.
// Depends on wspt_pkg, the three channel interfaces, the block and its checker.

module wheel_speed_pid_throttle_tb;
   import wspt_pkg::*;

   localparam int MAX_THROTTLE = 100;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 191;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   logic clock;
   logic reset;
   int   outstanding;
   int   failures;
   int   cycle_count = 0;
   int   rsp_stall_pct = 0;
   int   hold_off_len = 0;

   wspt_req_if req_ch ();
   wspt_rsp_if rsp_ch ();
   wspt_csr_if csr_ch ();

   wheel_speed_pid_throttle #(.MAX_THROTTLE(MAX_THROTTLE)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   wheel_speed_pid_throttle_check #(.MAX_THROTTLE(MAX_THROTTLE)) pid_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_pulse_count    (req_ch.pulse_count),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_throttle       (rsp_ch.throttle),
      .rsp_pulse_width_us (rsp_ch.pulse_width_us),
      .rsp_speed          (rsp_ch.speed),
      .rsp_clamp_state    (rsp_ch.clamp_state),
      .csr_valid          (csr_ch.valid),
      .csr_ready          (csr_ch.ready),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .outstanding        (outstanding),
      .failures           (failures)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("wheel_speed_pid_throttle regression: fail");
         $finish;
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            hold_left = hold_off_len;
            hold_off_len = 0;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_pulse(input int pulses, input int idle_pct);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.pulse_count <= PULSE_W'(pulses);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] set_speed,
                                input logic [CSR_DATA_W-1:0] speed_per_pulse,
                                input logic [CSR_DATA_W-1:0] gain_p,
                                input logic [CSR_DATA_W-1:0] gain_i,
                                input logic [CSR_DATA_W-1:0] gain_d,
                                input logic [CSR_DATA_W-1:0] step_ms,
                                input logic [CSR_DATA_W-1:0] deriv_scale);
      write_register(REG_SET_SPEED, set_speed);
      write_register(REG_SPEED_PER_PULSE, speed_per_pulse);
      write_register(REG_GAIN_P, gain_p);
      write_register(REG_GAIN_I, gain_i);
      write_register(REG_GAIN_D, gain_d);
      write_register(REG_STEP_MS, step_ms);
      write_register(REG_DERIV_SCALE, deriv_scale);
      write_register(REG_UNMAPPED, $urandom);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      int ss;
      int spp;
      int step_len;
      int idle_pct;
      int pulses;
      bit plausible;
      longint dscale;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pulse_count = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, both ends of the pulse range.
      send_pulse(0, 0);
      send_pulse(1023, 0);
      send_pulse(-1024, 0);
      send_pulse(1, 0);
      drain();

      // Half a metre per second per pulse with unit gain: rounding of halves and both clamps.
      load_settings(0, 32768, 65536, 0, 0, 100, 42950);
      send_pulse(-1, 0);
      send_pulse(1, 0);
      send_pulse(0, 0);
      send_pulse(-201, 0);
      send_pulse(-200, 0);
      drain();

      // Speed saturation, and a small negative sum that rounds to zero.
      load_settings(0, 65535, 1, 0, 0, 100, 42950);
      send_pulse(1023, 0);
      send_pulse(-1024, 0);
      send_pulse(5, 0);
      drain();

      // Largest error with the widest gains drives the integral term into its cap,
      // then the mirrored error winds the integral back.
      load_settings(32'hFF80_0000, 65535, 0, 24'hFF_FFFF, 24'hFF_FFFF, 1023, 32'hFFFF_FFFF);
      repeat (7) send_pulse(1023, 0);
      drain();
      load_settings(32'h007F_FFFF, 65535, 0, 24'hFF_FFFF, 24'hFF_FFFF, 1023, 32'hFFFF_FFFF);
      repeat (7) send_pulse(-1024, 0);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin idle_pct = 68; rsp_stall_pct = 0;  end
            2: begin idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         plausible = (phase < 4);
         ss = 0;
         spp = 1;
         if (plausible) begin
            ss = $urandom_range(327680);
            spp = $urandom_range(10000, 1000);
            step_len = $urandom_range(1000, 1);
            dscale = (64'd1 << 32) / (step_len * 1000);
            load_settings(ss, spp, $urandom_range(655360), (phase == 1) ? 0 : $urandom_range(1000),
                          $urandom_range(65536), step_len, dscale[31:0]);
         end else if (phase == 5) begin
            load_settings(32'h007F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         end else if (phase == 6) begin
            load_settings(32'hFF80_0000, 0, $urandom, $urandom, $urandom, 0, 0);
         end else begin
            load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end

         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 0 && item == 40) begin
               hold_off_len = HOLD_OFF_CYCLES;
            end
            if (plausible && $urandom_range(99) < 80) begin
               pulses = ss / spp + int'($urandom_range(12)) - 6;
            end else begin
               pulses = int'($urandom_range(2047)) - 1024;
            end
            send_pulse(pulses, idle_pct);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("wheel_speed_pid_throttle regression: pass");
      end else begin
         $display("wheel_speed_pid_throttle regression: fail");
      end
      $finish;
   end

endmodule
